// File: src/udiv_pkg.sv
// Package for the pipelined unsigned divider.
// Holds the default operand width; no dependencies.
package udiv_pkg;

   // Operand width used when the top level is not told otherwise.
   localparam int DEFAULT_DATA_WIDTH = 64;

endpackage

// File: src/unsigned_divider_64.sv
// Pipelined restoring unsigned divider: quotient, remainder, zero-divide flag.
// Depends on udiv_pkg for the default operand width.
//
// The block takes one req_ beat (dividend, divisor) per clock while the pipe
// is not held and returns one rsp_ beat per item, in order. Each of the
// DATA_WIDTH pipeline stages forms one quotient bit, top bit first, with a
// single (DATA_WIDTH+1)-bit subtract-and-compare. An accepted beat passes
// through the stage registers in order, and rsp_valid rises when it reaches
// the last stage; the sustained rate is one beat per cycle while the pipe
// is not held. The last stage is the output register. When rsp_ready is low
// with a result waiting, the whole pipe holds and req_ready drops in the same
// cycle; nothing is lost or repeated. A zero divisor gives an all-ones
// quotient, a remainder equal to the dividend and rsp_zero_divide set.
module unsigned_divider_64 #(
   parameter int DATA_WIDTH = udiv_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DATA_WIDTH-1:0] req_dividend,
   input  logic [DATA_WIDTH-1:0] req_divisor,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_WIDTH-1:0] rsp_quotient,
   output logic [DATA_WIDTH-1:0] rsp_remainder,
   output logic                  rsp_zero_divide
);
   import udiv_pkg::*;

   localparam int LAST = DATA_WIDTH - 1;

   // Per-stage registers. Stage s resolves quotient bit DATA_WIDTH-1-s.
   logic                  valid_ff [DATA_WIDTH];
   logic                  zero_ff  [DATA_WIDTH];
   logic [DATA_WIDTH-1:0] part_ff  [DATA_WIDTH];
   logic [DATA_WIDTH-1:0] quo_ff   [DATA_WIDTH];
   // Dividend (shifted, next bit on top) and divisor are not needed past
   // the second-to-last stage.
   logic [DATA_WIDTH-1:0] num_ff   [DATA_WIDTH-1];
   logic [DATA_WIDTH-1:0] den_ff   [DATA_WIDTH-1];

   // Whole pipe moves unless a finished result is held at the output.
   logic advance;
   assign advance   = !valid_ff[LAST] || rsp_ready;
   assign req_ready = advance;

   genvar s;
   generate
      for (s = 0; s < DATA_WIDTH; s++) begin : g_stage
         logic                  valid_src;
         logic                  zero_src;
         logic [DATA_WIDTH-1:0] part_src;
         logic [DATA_WIDTH-1:0] quo_src;
         logic [DATA_WIDTH-1:0] num_src;
         logic [DATA_WIDTH-1:0] den_src;
         logic [DATA_WIDTH:0]   shifted;
         logic [DATA_WIDTH+1:0] diff;
         logic                  ge;

         if (s == 0) begin : g_head
            assign valid_src = req_valid;
            assign zero_src  = (req_divisor == '0);
            assign part_src  = '0;
            assign quo_src   = '0;
            assign num_src   = req_dividend;
            assign den_src   = req_divisor;
         end else begin : g_body
            assign valid_src = valid_ff[s-1];
            assign zero_src  = zero_ff[s-1];
            assign part_src  = part_ff[s-1];
            assign quo_src   = quo_ff[s-1];
            assign num_src   = num_ff[s-1];
            assign den_src   = den_ff[s-1];
         end

         // Shift in the next dividend bit; the bit leaving the top is kept
         // so divisors above half range still divide exactly.
         assign shifted = {part_src, num_src[DATA_WIDTH-1]};
         assign diff    = {1'b0, shifted} - {2'b00, den_src};
         assign ge      = !diff[DATA_WIDTH+1];

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (advance) begin
               valid_ff[s] <= valid_src;
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               zero_ff[s] <= zero_src;
               part_ff[s] <= ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
               quo_ff[s]  <= {quo_src[DATA_WIDTH-2:0], ge};
            end
         end

         if (s < LAST) begin : g_carry
            always_ff @(posedge clock) begin
               if (advance) begin
                  num_ff[s] <= {num_src[DATA_WIDTH-2:0], 1'b0};
                  den_ff[s] <= den_src;
               end
            end
         end
      end
   endgenerate

   assign rsp_valid       = valid_ff[LAST];
   assign rsp_quotient    = quo_ff[LAST];
   assign rsp_remainder   = part_ff[LAST];
   assign rsp_zero_divide = zero_ff[LAST];

   // Zero divisor subtracts nothing at every step: every quotient bit set.
   a_zero_all_ones : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_divide |-> rsp_quotient == '1)
      else $error("zero divide without all-ones quotient");

   // Valid bits walk one stage per advancing cycle.
   a_valid_walk : assert property (@(posedge clock) disable iff (reset)
      advance |=> valid_ff[1] == $past(valid_ff[0]))
      else $error("valid bit lost between stages");

   // A held pipe keeps the waiting result intact.
   a_hold_result : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(part_ff[LAST]) && $stable(quo_ff[LAST]))
      else $error("held result changed");

   // Ready tracks only the output stall.
   a_ready_stall : assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready does not follow output stall");

   // Reset empties the pipe.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
